// File: src/ihpf_pkg.sv
package ihpf_pkg;

  // Histogram geometry
  localparam int BINS  = 1024;
  localparam int BIN_W = $clog2(BINS);

  // Field and register widths
  localparam int TS_W       = 32;
  localparam int CNT_W      = 16;
  localparam int BL_W       = 11;
  localparam int RL_W       = 16;
  localparam int PER_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [BL_W-1:0]  BIN_LIMIT_RST    = BL_W'(1000);
  localparam logic [RL_W-1:0]  RECORD_LIMIT_RST = RL_W'(1000);
  localparam logic [CNT_W-1:0] CNT_MAX          = '1;
  localparam logic [RL_W-1:0]  MIN_RECORDS      = RL_W'(2);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIN_LIMIT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LIMIT = CFG_IDX_W'(1);

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // record request taken this cycle
    logic sweep;     // histogram address comes from the sweep counter
    logic clr_we;    // write zero at the sweep address
    logic upd_we;    // write back incremented bin
    logic idx_clr;   // sweep counter back to zero
    logic idx_inc;   // sweep counter advance
    logic scan_rd;   // read issued is a scan read
    logic best_clr;  // reset running maximum
    logic out_load;  // load result register
    logic run_clr;   // clear per-run state
  } ihpf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic idx_last;  // sweep counter at last bin
    logic few;       // fewer than two records kept
  } ihpf_sts_t;

endpackage

// File: src/ihpf_ctrl.sv
module ihpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_record,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ihpf_pkg::ihpf_sts_t sts,
  output ihpf_pkg::ihpf_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r & out_stall;
    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep   = 1'b1;
        cmd.clr_we  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          last_nxt   = in_last_record;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd_we = 1'b1;
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (sts.few) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.best_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.sweep   = 1'b1;
        cmd.clr_we  = 1'b1;
        cmd.scan_rd = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          cmd.run_clr   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: src/ihpf_dp.sv
module ihpf_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ihpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ihpf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [ihpf_pkg::TS_W-1:0]            in_timestamp,
  input  ihpf_pkg::ihpf_cmd_t                  cmd,
  output ihpf_pkg::ihpf_sts_t                  sts,
  output logic [ihpf_pkg::PER_W-1:0]           out_period,
  output logic [ihpf_pkg::CNT_W-1:0]           out_occurrences,
  output logic [ihpf_pkg::RL_W-1:0]            out_interval_count,
  output logic                                 out_status,
  output logic                                 out_truncated
);

  // Configuration
  logic [ihpf_pkg::BL_W-1:0] bin_limit_r;
  logic [ihpf_pkg::RL_W-1:0] record_limit_r;

  // Run state
  logic [ihpf_pkg::TS_W-1:0]  prev_time_r;
  logic [ihpf_pkg::RL_W-1:0]  kept_r;
  logic                       dropped_r;

  // Histogram RAM
  logic [ihpf_pkg::CNT_W-1:0] mem [ihpf_pkg::BINS];
  logic [ihpf_pkg::CNT_W-1:0] rdata_r;
  logic [ihpf_pkg::BIN_W-1:0] rd_addr;
  logic [ihpf_pkg::BIN_W-1:0] wr_addr;
  logic [ihpf_pkg::CNT_W-1:0] wr_data;
  logic                       wr_en;

  // Record update
  logic [ihpf_pkg::TS_W-1:0]  diff;
  logic                       keep;
  logic                       inc_en;
  logic                       inc_en_r;
  logic [ihpf_pkg::BIN_W-1:0] inc_addr_r;

  // Sweep and maximum search
  logic [ihpf_pkg::BIN_W-1:0] scan_idx_r;
  logic [ihpf_pkg::BIN_W-1:0] cmp_idx_r;
  logic                       cmp_v_r;
  logic [ihpf_pkg::BIN_W-1:0] best_bin_r;
  logic [ihpf_pkg::CNT_W-1:0] best_cnt_r;

  always_comb begin
    diff   = in_timestamp - prev_time_r;
    keep   = (kept_r < record_limit_r);
    inc_en = keep && (kept_r != '0) && (in_timestamp >= prev_time_r)
             && (diff < ihpf_pkg::TS_W'(bin_limit_r))
             && (diff < ihpf_pkg::TS_W'(ihpf_pkg::BINS));
    rd_addr = cmd.sweep ? scan_idx_r : diff[ihpf_pkg::BIN_W-1:0];
    wr_en   = cmd.clr_we
              | (cmd.upd_we & inc_en_r & (rdata_r != ihpf_pkg::CNT_MAX));
    wr_addr = cmd.clr_we ? scan_idx_r : inc_addr_r;
    wr_data = cmd.clr_we ? '0 : rdata_r + ihpf_pkg::CNT_W'(1);
  end

  // Read-first single write, single read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_limit_r    <= ihpf_pkg::BIN_LIMIT_RST;
      record_limit_r <= ihpf_pkg::RECORD_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == ihpf_pkg::REG_BIN_LIMIT) begin
        bin_limit_r <= cfg_wdata[ihpf_pkg::BL_W-1:0];
      end
      if (cfg_index == ihpf_pkg::REG_RECORD_LIMIT) begin
        record_limit_r <= cfg_wdata[ihpf_pkg::RL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r <= '0;
      kept_r      <= '0;
      dropped_r   <= 1'b0;
      inc_en_r    <= 1'b0;
    end else begin
      inc_en_r <= cmd.accept & inc_en;
      if (cmd.run_clr) begin
        prev_time_r <= '0;
        kept_r      <= '0;
        dropped_r   <= 1'b0;
      end else if (cmd.accept) begin
        if (keep) begin
          prev_time_r <= in_timestamp;
          kept_r      <= kept_r + ihpf_pkg::RL_W'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    inc_addr_r <= diff[ihpf_pkg::BIN_W-1:0];
    cmp_idx_r  <= scan_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      cmp_v_r    <= 1'b0;
      best_bin_r <= '0;
      best_cnt_r <= '0;
    end else begin
      cmp_v_r <= cmd.scan_rd;
      if (cmd.idx_clr) begin
        scan_idx_r <= '0;
      end else if (cmd.idx_inc) begin
        scan_idx_r <= scan_idx_r + ihpf_pkg::BIN_W'(1);
      end
      // strict compare keeps the lowest bin on a tie
      if (cmd.best_clr) begin
        best_bin_r <= '0;
        best_cnt_r <= '0;
      end else if (cmp_v_r && (rdata_r > best_cnt_r)) begin
        best_bin_r <= cmp_idx_r;
        best_cnt_r <= rdata_r;
      end
    end
  end

  // Result register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_truncated <= dropped_r;
      if (sts.few) begin
        out_period         <= '0;
        out_occurrences    <= '0;
        out_interval_count <= '0;
        out_status         <= 1'b1;
      end else begin
        out_period         <= ihpf_pkg::PER_W'(best_bin_r);
        out_occurrences    <= best_cnt_r;
        out_interval_count <= kept_r - ihpf_pkg::RL_W'(1);
        out_status         <= 1'b0;
      end
    end
  end

  assign sts.idx_last = (scan_idx_r == ihpf_pkg::BIN_W'(ihpf_pkg::BINS - 1));
  assign sts.few      = (kept_r < ihpf_pkg::MIN_RECORDS);

endmodule

// File: src/interval_histogram_period_finder_top.sv
// Interval histogram period finder. A run of timestamp requests (the last one
// flagged by in_last_record) is reduced to one result: the most frequent
// interval between consecutive kept records (lowest bin on a tie), its count,
// the number of intervals, a status (1 when fewer than two records were kept)
// and a truncation flag (records past record_limit were dropped). Intervals
// that are negative or at or above min(bin_limit, 1024) are not counted; bin
// counts saturate at 65535. A record is taken only after the read-modify-write
// of the previous record's bin in the 1024 x 16 histogram RAM (one read and
// one write port) is done. The flagged record adds a sweep of all 1024 bins,
// a drain state for the compare of the last bin, and the result load, which
// waits while an earlier result is held by out_stall: the sweep reads every
// bin for the maximum search and writes it back to zero, so the next run
// starts clean. A run with fewer than two records skips the sweep and goes
// straight to the result load. After reset the block clears all 1024 bins
// with in_stall high; configuration writes are taken at any time but should
// only be issued while the block is idle. Results sit in an output register,
// so a new run can start while the previous result waits.
module interval_histogram_period_finder_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [ihpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ihpf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // record requests
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ihpf_pkg::TS_W-1:0]        in_timestamp,
  input  logic                             in_last_record,
  // result requests
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ihpf_pkg::PER_W-1:0]       out_period,
  output logic [ihpf_pkg::CNT_W-1:0]       out_occurrences,
  output logic [ihpf_pkg::RL_W-1:0]        out_interval_count,
  output logic                             out_status,
  output logic                             out_truncated
);

  ihpf_pkg::ihpf_cmd_t cmd;
  ihpf_pkg::ihpf_sts_t sts;

  // Sequencer: clearing pass, record update, sweep, result hand-off
  ihpf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_record (in_last_record),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  // Interval math, histogram RAM, max search and result register
  ihpf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_timestamp       (in_timestamp),
    .cmd                (cmd),
    .sts                (sts),
    .out_period         (out_period),
    .out_occurrences    (out_occurrences),
    .out_interval_count (out_interval_count),
    .out_status         (out_status),
    .out_truncated      (out_truncated)
  );

endmodule

// File: src/ihpf_checker.sv
module ihpf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [ihpf_pkg::PER_W-1:0]       out_period,
  input logic [ihpf_pkg::CNT_W-1:0]       out_occurrences,
  input logic [ihpf_pkg::RL_W-1:0]        out_interval_count,
  input logic                             out_status,
  input logic                             out_truncated
);

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> $stable(out_period)
      && $stable(out_occurrences) && $stable(out_interval_count)
      && $stable(out_status) && $stable(out_truncated))
    else $error("stalled result changed");

  // each record taken holds off the next while its bin is written back
  a_rmw_gap: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("record taken back to back");

  // short runs report zeros
  a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_status |-> out_period == '0
      && out_occurrences == '0 && out_interval_count == '0)
    else $error("short run result not zero");

  // a bin never counts more intervals than were formed
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid |-> out_occurrences <= out_interval_count)
    else $error("occurrences exceed interval count");

endmodule

bind interval_histogram_period_finder_top ihpf_checker u_ihpf_checker (.*);
